[rtl/conv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_pkg: shared types and constants for the 3x3 streaming convolution
// Pixel, window column and result types, register indexes and sizes.
// ----------------------------------------------------------------------------
package conv_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int KERNEL_SIZE = 3;

  localparam int PIX_W      = 16;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int SUM_W      = 36;
  localparam int IDX_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KERNEL_SIZE * PIX_W;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);

  // result queue between the datapath and the output port
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEFF_TOP    = 3'd2,
    REG_COEFF_MIDDLE = 3'd3,
    REG_COEFF_BOTTOM = 3'd4
  } cfg_reg_e;

  typedef logic signed [PIX_W-1:0] pix_t;

  // one window column (or one coefficient column): top, middle, bottom row
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // per-item tag that follows the datapath
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } res_t;

  function automatic logic signed [SUM_W-1:0] sext_prod(input logic signed [PROD_W-1:0] p);
    sext_prod = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

[rtl/conv_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module conv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/conv_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_cell: one column of the 3x3 window
// Holds a pixel column, passes it to its left neighbor on each shift, and
// forms the weighted column sum through a product register and a sum register.
// ----------------------------------------------------------------------------
module conv_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            shift,
  input  conv_pkg::col_t                  col_in,
  input  conv_pkg::col_t                  coeff,
  output conv_pkg::col_t                  col_out,
  output logic signed [conv_pkg::SUM_W-1:0] sum_out
);
  import conv_pkg::*;

  col_t                     col_q;
  logic signed [PROD_W-1:0] prod_top;
  logic signed [PROD_W-1:0] prod_mid;
  logic signed [PROD_W-1:0] prod_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (shift) begin
      col_q <= col_in;
    end
  end

  // stage 1: three products, stage 2: column sum
  always_ff @(posedge clk) begin
    prod_top <= $signed(col_q.top) * $signed(coeff.top);
    prod_mid <= $signed(col_q.mid) * $signed(coeff.mid);
    prod_bot <= $signed(col_q.bot) * $signed(coeff.bot);
    sum_out  <= sext_prod(prod_top) + sext_prod(prod_mid) + sext_prod(prod_bot);
  end

  assign col_out = col_q;

endmodule

[rtl/conv2d_3x3_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_3x3_stream: streaming 3x3 2-D convolution
// Raster-order 16-bit pixels in; exact 36-bit weighted sums of each interior
// 3x3 neighborhood out, tagged with the window center and end of frame.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while pixel_stall is low.
// Path of a result after the transfer of the pixel that completes its window:
//   line store read, window shift, products, column sums, result queue.
// An 8-entry result queue absorbs output stalls; pixel_stall rises only when
//   eight results are queued or in flight.
// Reset (rst, synchronous): counters, window, queue and registers go to their
//   defaults (5x5 frame, zero kernel); line stores are not cleared.
// ----------------------------------------------------------------------------
module conv2d_3x3_stream (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic signed [conv_pkg::PIX_W-1:0]   pixel,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [conv_pkg::SUM_W-1:0]   out_value,
  output logic [conv_pkg::IDX_W-1:0]          center_row,
  output logic [conv_pkg::IDX_W-1:0]          center_col,
  output logic                                frame_last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [conv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [conv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import conv_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]     image_width;
  logic [SIZE_W-1:0]     image_height;
  logic [CFG_DATA_W-1:0] coeff_top;
  logic [CFG_DATA_W-1:0] coeff_middle;
  logic [CFG_DATA_W-1:0] coeff_bottom;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(5);
      image_height <= SIZE_W'(5);
      coeff_top    <= '0;
      coeff_middle <= '0;
      coeff_bottom <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        REG_COEFF_TOP:    coeff_top    <= cfg_data;
        REG_COEFF_MIDDLE: coeff_middle <= cfg_data;
        REG_COEFF_BOTTOM: coeff_bottom <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Sizes in use: clamped to 3..max
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;

  always_comb begin
    if (image_width < SIZE_W'(3)) begin
      width_eff = SIZE_W'(3);
    end else if (image_width > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = image_width;
    end
    if (image_height < SIZE_W'(3)) begin
      height_eff = SIZE_W'(3);
    end else if (image_height > SIZE_W'(MAX_HEIGHT)) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  // --------------------------------------------------------------------------
  // Input transfer and raster counters
  // --------------------------------------------------------------------------
  logic             pix_xfer;
  logic [IDX_W-1:0] row_count;
  logic [IDX_W-1:0] col_count;
  logic             col_wrap;
  logic             row_wrap;
  meta_t            meta_in;

  // pend counts results in flight plus results queued; it bounds queue use
  logic [FIFO_CW-1:0] pend;

  assign pixel_stall = (pend == FIFO_CW'(FIFO_DEPTH));
  assign pix_xfer    = pixel_valid && !pixel_stall;

  assign col_wrap = ({1'b0, col_count} + SIZE_W'(1)) >= width_eff;
  assign row_wrap = ({1'b0, row_count} + SIZE_W'(1)) >= height_eff;

  always_comb begin
    meta_in.emit = (row_count >= IDX_W'(2)) && (col_count >= IDX_W'(2));
    meta_in.last = row_wrap && col_wrap;
    meta_in.row  = row_count - IDX_W'(1);
    meta_in.col  = col_count - IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (pix_xfer) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_count + IDX_W'(1);
      end else begin
        col_count <= col_count + IDX_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: A holds the previous line, B the one before it.
  // Both are read at the current column on transfer; A takes the new pixel
  // at once (read-first), B takes A's old value in the following cycle.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]   above_q;
  logic [PIX_W-1:0]   above2_q;
  logic               v1;
  meta_t              m1;
  pix_t               px1;
  logic [LINE_AW-1:0] addr1;

  conv_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk   (clk),
    .we    (pix_xfer),
    .waddr (col_count[LINE_AW-1:0]),
    .wdata (pixel),
    .re    (pix_xfer),
    .raddr (col_count[LINE_AW-1:0]),
    .rdata (above_q)
  );

  conv_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk   (clk),
    .we    (v1),
    .waddr (addr1),
    .wdata (above_q),
    .re    (pix_xfer),
    .raddr (col_count[LINE_AW-1:0]),
    .rdata (above2_q)
  );

  always_ff @(posedge clk) begin
    px1   <= pixel;
    m1    <= meta_in;
    addr1 <= col_count[LINE_AW-1:0];
  end

  // --------------------------------------------------------------------------
  // Window: a chain of three column cells. The newest column enters the
  // right cell; each shift moves every column one cell to the left.
  // --------------------------------------------------------------------------
  col_t                    new_col;
  col_t                    cell_col  [KERNEL_SIZE];
  col_t                    cell_coef [KERNEL_SIZE];
  logic signed [SUM_W-1:0] cell_sum  [KERNEL_SIZE];

  always_comb begin
    new_col.top = above2_q;
    new_col.mid = above_q;
    new_col.bot = px1;
  end

  for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_cell
    col_t chain_in;

    // left coefficient in the low bits of each row register
    assign cell_coef[j].top = coeff_top[j*PIX_W +: PIX_W];
    assign cell_coef[j].mid = coeff_middle[j*PIX_W +: PIX_W];
    assign cell_coef[j].bot = coeff_bottom[j*PIX_W +: PIX_W];

    if (j == KERNEL_SIZE - 1) begin : g_head
      assign chain_in = new_col;
    end else begin : g_link
      assign chain_in = cell_col[j+1];
    end

    conv_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (v1),
      .col_in  (chain_in),
      .coeff   (cell_coef[j]),
      .col_out (cell_col[j]),
      .sum_out (cell_sum[j])
    );
  end

  // Tag pipeline alongside the cells: window ready (2), products (3),
  // column sums (4); final add goes straight into the queue.
  logic  v2, v3, v4;
  meta_t m2, m3, m4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= pix_xfer;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    m2 <= m1;
    m3 <= m2;
    m4 <= m3;
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic               fifo_push;
  logic               fifo_pop;
  res_t               res_in;
  res_t               res_head;

  assign fifo_push = v4 && m4.emit;
  assign fifo_pop  = out_valid && !out_stall;

  always_comb begin
    res_in.value = cell_sum[0] + cell_sum[1] + cell_sum[2];
    res_in.row   = m4.row;
    res_in.col   = m4.col;
    res_in.last  = m4.last;
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pend     <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({fifo_push, fifo_pop})
        2'b10:   fifo_cnt <= fifo_cnt + FIFO_CW'(1);
        2'b01:   fifo_cnt <= fifo_cnt - FIFO_CW'(1);
        default: fifo_cnt <= fifo_cnt;
      endcase
      case ({pix_xfer && meta_in.emit, fifo_pop})
        2'b10:   pend <= pend + FIFO_CW'(1);
        2'b01:   pend <= pend - FIFO_CW'(1);
        default: pend <= pend;
      endcase
    end
  end

  assign res_head   = fifo_mem[rd_ptr];
  assign out_valid  = (fifo_cnt != '0);
  assign out_value  = res_head.value;
  assign center_row = res_head.row;
  assign center_col = res_head.col;
  assign frame_last = res_head.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= FIFO_CW'(FIFO_DEPTH))
    else $error("pending result count above queue depth");

  a_queue_in_pend: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= pend)
    else $error("queued results exceed pending count");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> (fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || fifo_pop)
    else $error("result queue overflow");

  a_center_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (center_row != '0) && (center_col != '0))
    else $error("result with border center");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (pend == FIFO_CW'(FIFO_DEPTH)) && (fifo_cnt != '0 || v1 || v2 || v3 || v4))
    else $error("input stalled without full result budget");

endmodule

[sim/tb_conv2d_3x3_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_3x3_stream: self-checking bench for the streaming 3x3 convolution
// Drives raster-order pixel frames and kernel/size register writes, predicts
// every interior window sum with its center and end-of-frame flag, and checks
// each result transfer in order against the prediction.
// ----------------------------------------------------------------------------
module tb_conv2d_3x3_stream;
  import conv_pkg::*;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 9;
  localparam int          SETTLE_CYCLES = 12;     // covers the result path, plus margin
  localparam int          DRAIN_LIMIT   = 50000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RANDOM_ITEMS  = 300;
  localparam int          MAX_REPORTS   = 30;
  localparam int          SMALL_FRAME   = 120;    // cap on pixels per random frame
  localparam int unsigned RESET_SIZE    = 5;
  localparam pix_t        PIX_MIN       = 16'sh8000;
  localparam pix_t        PIX_MAX       = 16'sh7FFF;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_BURSTY} stall_mode_e;

  // --------------------------------------------------------------------------
  // Expected-result tracker: mirrors the line stores, window and counters and
  // keeps the queue of sums still owed by the block.
  // --------------------------------------------------------------------------
  class conv_sum_tracker;
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [CFG_DATA_W-1:0] kernel_rows [KERNEL_SIZE];
    pix_t                  prev_line   [MAX_WIDTH];
    pix_t                  prev2_line  [MAX_WIDTH];
    pix_t                  window      [KERNEL_SIZE*KERNEL_SIZE];
    int unsigned           row_cnt;
    int unsigned           col_cnt;
    res_t                  pending_sums [$];
    int                    errors;

    function new();
      width_reg  = SIZE_W'(RESET_SIZE);
      height_reg = SIZE_W'(RESET_SIZE);
      foreach (kernel_rows[i]) kernel_rows[i] = '0;
      foreach (prev_line[i]) begin
        prev_line[i]  = '0;
        prev2_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
      errors  = 0;
    endfunction

    function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned maxv);
      if (v < KERNEL_SIZE) return KERNEL_SIZE;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, MAX_HEIGHT);
    endfunction

    function bit at_frame_start();
      return row_cnt == 0 && col_cnt == 0;
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    function bit count_error();
      errors++;
      return errors <= MAX_REPORTS;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg      = data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_reg     = data[SIZE_W-1:0];
        REG_COEFF_TOP:    kernel_rows[0] = data;
        REG_COEFF_MIDDLE: kernel_rows[1] = data;
        REG_COEFF_BOTTOM: kernel_rows[2] = data;
        default: ;
      endcase
    endfunction

    // one accepted pixel: shift the window, update stores, maybe owe a sum
    function void take_pixel(pix_t px);
      int unsigned w, h, ci;
      int          i, j;
      pix_t        above, above2;
      longint      acc;
      res_t        sum;
      w      = clamp_size(width_reg, MAX_WIDTH);
      h      = clamp_size(height_reg, MAX_HEIGHT);
      ci     = col_cnt % MAX_WIDTH;
      above  = prev_line[ci];
      above2 = prev2_line[ci];
      prev2_line[ci] = above;
      prev_line[ci]  = px;
      for (i = 0; i < KERNEL_SIZE; i++) begin
        window[i*KERNEL_SIZE]     = window[i*KERNEL_SIZE + 1];
        window[i*KERNEL_SIZE + 1] = window[i*KERNEL_SIZE + 2];
      end
      window[2] = above2;
      window[5] = above;
      window[8] = px;
      if (row_cnt >= 2 && col_cnt >= 2) begin
        acc = 0;
        for (i = 0; i < KERNEL_SIZE; i++)
          for (j = 0; j < KERNEL_SIZE; j++)
            acc += longint'(window[i*KERNEL_SIZE + j]) *
                   longint'(pix_t'(kernel_rows[i][j*PIX_W +: PIX_W]));
        sum.value = acc[SUM_W-1:0];
        sum.row   = IDX_W'(row_cnt - 1);
        sum.col   = IDX_W'(col_cnt - 1);
        sum.last  = (row_cnt + 1 >= h) && (col_cnt + 1 >= w);
        pending_sums.push_back(sum);
      end
      if (col_cnt + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
      end else begin
        col_cnt = col_cnt + 1;
      end
    endfunction

    function void match_result(logic signed [SUM_W-1:0] value, logic [IDX_W-1:0] row,
                               logic [IDX_W-1:0] col, logic last);
      res_t want;
      if (pending_sums.size() == 0) begin
        if (count_error())
          $display("%0t: unexpected result, expected none, got value %0d at (%0d,%0d) last %0b",
                   $time, value, row, col, last);
        return;
      end
      want = pending_sums.pop_front();
      if (value !== want.value && count_error())
        $display("%0t: out_value mismatch, expected %0d, got %0d", $time, want.value, value);
      if (row !== want.row && count_error())
        $display("%0t: center_row mismatch, expected %0d, got %0d", $time, want.row, row);
      if (col !== want.col && count_error())
        $display("%0t: center_col mismatch, expected %0d, got %0d", $time, want.col, col);
      if (last !== want.last && count_error())
        $display("%0t: frame_last mismatch, expected %0b, got %0b", $time, want.last, last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    pixel_valid = 1'b0;
  logic                    pixel_stall;
  pix_t                    pixel       = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic signed [SUM_W-1:0] out_value;
  logic [IDX_W-1:0]        center_row;
  logic [IDX_W-1:0]        center_col;
  logic                    frame_last;
  logic                    cfg_valid   = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;

  conv_sum_tracker tracker = new();

  // sender pacing and receiver hold-off control
  int unsigned pixel_count   = 0;
  int unsigned burst_left    = 0;
  bit          steady_sender = 1'b0;   // no gaps between transfers
  bit          hold_request  = 1'b0;
  bit          hold_active   = 1'b0;

  conv2d_3x3_stream u_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .center_row  (center_row),
    .center_col  (center_col),
    .frame_last  (frame_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them run in step with the rising edge: drive with
  // nonblocking assignments right after an edge, sample handshakes at the edge.
  // --------------------------------------------------------------------------
  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 15))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      2:       return '0;
      3:       return '1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  // size registers only look at the low bits; junk above them must not matter
  function automatic logic [CFG_DATA_W-1:0] size_word(logic [SIZE_W-1:0] v);
    logic [CFG_DATA_W-1:0] d;
    d = rand_word();
    d[SIZE_W-1:0] = v;
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] coeff_word();
    case ($urandom_range(0, 9))
      0:       return {KERNEL_SIZE{PIX_MIN}};
      1:       return {KERNEL_SIZE{PIX_MAX}};
      2:       return '0;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] kernel_row(pix_t left, pix_t center, pix_t right);
    return {right, center, left};
  endfunction

  // mostly small frames; a few that clamp up to 3 or stretch one side
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return SIZE_W'($urandom_range(0, KERNEL_SIZE - 1));
      1:       return SIZE_W'($urandom_range(13, 40));
      default: return SIZE_W'($urandom_range(KERNEL_SIZE, 12));
    endcase
  endfunction

  // one pixel transfer; the sender then maybe ends its burst with a gap
  task automatic push_pixel(input pix_t px);
    int unsigned gap;
    pixel_valid <= 1'b1;
    pixel       <= px;
    do @(posedge clk); while (pixel_stall);
    tracker.take_pixel(px);
    pixel_count++;
    if (burst_left > 0) burst_left--;
    if (!steady_sender && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic push_frames(input int unsigned frames);
    int unsigned count;
    count = frames * tracker.frame_pixels();
    repeat (count) push_pixel(rand_pixel());
  endtask

  // register transfer; the caller drops cfg_valid after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  // sender pauses until every owed result is out, then lets border pixels
  // (which give no result) flush through before any register write
  task automatic wait_for_idle();
    pixel_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check every result transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.match_result(out_value, center_row, center_col, frame_last);
  end

  // Receiver stall pattern: segments of random kind and length, including runs
  // with no stall at all. On request it holds off for a long stretch so the
  // result queue fills and the block has to stall its pixel input.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned seg, pct, period, k;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        hold_active = 1'b0;
      end else begin
        mode   = stall_mode_e'($urandom_range(STALL_NONE, STALL_BURSTY));
        seg    = $urandom_range(8, 120);
        pct    = $urandom_range(20, 80);
        period = $urandom_range(2, 7);
        for (k = 0; k < seg && !hold_request; k++) begin
          @(posedge clk);
          case (mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < pct);
            STALL_PERIODIC: out_stall <= (k % period == 0);
            STALL_BURSTY:   out_stall <= ((k / period) % 2 == 0);
            default:        out_stall <= 1'b0;
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_start, k, n;
    logic [SIZE_W-1:0] w, h;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: 5x5 frame, all-zero kernel
    push_frames(1);

    // directed: 3x3 frames, one result each, every register written
    wait_for_idle();
    write_reg(REG_IMAGE_WIDTH, size_word(SIZE_W'(KERNEL_SIZE)));
    write_reg(REG_IMAGE_HEIGHT, size_word(SIZE_W'(KERNEL_SIZE)));
    write_reg(REG_COEFF_TOP, kernel_row(PIX_MIN, PIX_MIN, PIX_MIN));
    write_reg(REG_COEFF_MIDDLE, kernel_row(PIX_MIN, PIX_MIN, PIX_MIN));
    write_reg(REG_COEFF_BOTTOM, kernel_row(PIX_MIN, PIX_MIN, PIX_MIN));
    cfg_valid <= 1'b0;
    repeat (KERNEL_SIZE * KERNEL_SIZE) push_pixel(PIX_MIN);   // largest positive sum
    repeat (KERNEL_SIZE * KERNEL_SIZE) push_pixel(PIX_MAX);   // most negative sum

    // distinct weights per tap: any flip or transpose of the kernel shows up
    wait_for_idle();
    write_reg(REG_COEFF_TOP, kernel_row(16'sd1, 16'sd2, 16'sd4));
    write_reg(REG_COEFF_MIDDLE, kernel_row(16'sd8, -16'sd16, 16'sd32));
    write_reg(REG_COEFF_BOTTOM, kernel_row(16'sd64, 16'sd128, -16'sd256));
    cfg_valid <= 1'b0;
    for (k = 0; k < KERNEL_SIZE * KERNEL_SIZE; k++)
      push_pixel(k[0] ? pix_t'(-(k + 1) * 1000) : pix_t'((k + 1) * 1000));

    // random phases of whole frames; most start with a fresh setting
    random_start = pixel_count;
    while (pixel_count - random_start < RANDOM_ITEMS) begin
      steady_sender = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0) begin
        wait_for_idle();
        w = pick_size();
        h = pick_size();
        if (tracker.clamp_size(w, MAX_WIDTH) * tracker.clamp_size(h, MAX_HEIGHT) > SMALL_FRAME)
          h = SIZE_W'(KERNEL_SIZE);
        write_reg(REG_IMAGE_WIDTH, size_word(w));
        write_reg(REG_IMAGE_HEIGHT, size_word(h));
        if ($urandom_range(0, 1)) write_reg(REG_COEFF_TOP, coeff_word());
        if ($urandom_range(0, 1)) write_reg(REG_COEFF_MIDDLE, coeff_word());
        if ($urandom_range(0, 1)) write_reg(REG_COEFF_BOTTOM, coeff_word());
        cfg_valid <= 1'b0;
      end
      push_frames($urandom_range(1, 2));
    end

    // back-pressure: receiver holds off while the sender keeps offering
    wait_for_idle();
    write_reg(REG_IMAGE_WIDTH, size_word(SIZE_W'(12)));
    write_reg(REG_IMAGE_HEIGHT, size_word(SIZE_W'(12)));
    write_reg(REG_COEFF_MIDDLE, coeff_word());
    cfg_valid <= 1'b0;
    steady_sender = 1'b1;
    hold_request  = 1'b1;
    wait (hold_active);
    push_frames(1);
    steady_sender = 1'b0;

    // size shrinks mid-frame: counters beyond the new size wrap at once
    wait_for_idle();
    write_reg(REG_IMAGE_WIDTH, size_word(SIZE_W'(10)));
    write_reg(REG_IMAGE_HEIGHT, size_word(SIZE_W'(10)));
    cfg_valid <= 1'b0;
    repeat (35) push_pixel(rand_pixel());
    wait_for_idle();
    write_reg(REG_IMAGE_WIDTH, size_word(SIZE_W'(4)));
    write_reg(REG_IMAGE_HEIGHT, size_word(SIZE_W'(KERNEL_SIZE)));
    cfg_valid <= 1'b0;
    do push_pixel(rand_pixel()); while (!tracker.at_frame_start());

    // writes to unused register indexes change nothing
    wait_for_idle();
    for (n = REG_COEFF_BOTTOM + 1; n < (1 << CFG_IDX_W); n++)
      write_reg(CFG_IDX_W'(n), rand_word());
    cfg_valid <= 1'b0;
    push_frames(1);

    // largest sizes: all-ones width clamps to the maximum line, zero height
    // to 3; part of a long first line, then a narrower width ends it at once
    wait_for_idle();
    write_reg(REG_IMAGE_WIDTH, size_word('1));
    write_reg(REG_IMAGE_HEIGHT, size_word('0));
    write_reg(REG_COEFF_TOP, coeff_word());
    cfg_valid <= 1'b0;
    repeat (40) push_pixel(rand_pixel());
    wait_for_idle();
    write_reg(REG_IMAGE_WIDTH, size_word(SIZE_W'(4)));
    cfg_valid <= 1'b0;
    do push_pixel(rand_pixel()); while (!tracker.at_frame_start());

    // all-ones height: a tall strip, then a short height ends the frame early
    wait_for_idle();
    write_reg(REG_IMAGE_WIDTH, size_word(SIZE_W'(KERNEL_SIZE)));
    write_reg(REG_IMAGE_HEIGHT, size_word('1));
    write_reg(REG_COEFF_BOTTOM, coeff_word());
    cfg_valid <= 1'b0;
    repeat (30) push_pixel(rand_pixel());
    wait_for_idle();
    write_reg(REG_IMAGE_HEIGHT, size_word(SIZE_W'(KERNEL_SIZE)));
    cfg_valid <= 1'b0;
    do push_pixel(rand_pixel()); while (!tracker.at_frame_start());
    push_frames(1);

    // drain with a bound, then wait out SETTLE_CYCLES for stray results
    pixel_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && tracker.pending() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

[conv2d_3x3_stream.f]
rtl/conv_pkg.sv
rtl/conv_ram.sv
rtl/conv_cell.sv
rtl/conv2d_3x3_stream.sv
sim/tb_conv2d_3x3_stream.sv
